// ===== hdl/dss_pkg.sv =====
// shared types, constants and register defaults of the strike scheduler
package dss_pkg;

   // history depth default
   localparam int SEEN_DEPTH_DEF = 16;

   // configuration port shape
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STRIKE_KIND = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DELAY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PULSE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PULSE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LATE    = 3'd4;

   // register reset values
   localparam logic [7:0]  STRIKE_KIND_RST = 8'd1;
   localparam logic [15:0] MAX_DELAY_RST   = 16'd10000;
   localparam logic [15:0] MIN_PULSE_RST   = 16'd1;
   localparam logic [15:0] MAX_PULSE_RST   = 16'd100;
   localparam logic [15:0] MAX_LATE_RST    = 16'd50;

   // command codes
   localparam logic CMD_EVENT = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // result status codes
   localparam logic [3:0] ST_INVALID      = 4'd0;
   localparam logic [3:0] ST_DUPLICATE    = 4'd1;
   localparam logic [3:0] ST_BUSY         = 4'd2;
   localparam logic [3:0] ST_ARMED_FUTURE = 4'd3;
   localparam logic [3:0] ST_ARMED_NOW    = 4'd4;
   localparam logic [3:0] ST_IDLE         = 4'd5;
   localparam logic [3:0] ST_WAITING      = 4'd6;
   localparam logic [3:0] ST_EXPIRED      = 4'd7;
   localparam logic [3:0] ST_FIRE         = 4'd8;

   // input beat
   typedef struct packed {
      logic        cmd;
      logic [31:0] now_ms;
      logic [7:0]  event_kind;
      logic [31:0] strike_id;
      logic [15:0] delay_ms;
      logic [15:0] pulse_request;
   } req_type;

   // result beat
   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] pulse_ms;
   } rsp_type;

   // configuration registers
   typedef struct packed {
      logic [7:0]  strike_kind_code;
      logic [15:0] max_delay_ms;
      logic [15:0] min_pulse_ms;
      logic [15:0] max_pulse_ms;
      logic [15:0] max_late_ms;
   } cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic        cmd;
      logic        ok;
      logic [31:0] now_ms;
      logic [31:0] strike_id;
      logic [15:0] delay_ms;
      logic [15:0] pulse_ms;
   } work_type;

endpackage

// ===== hdl/dss_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module dss_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/dss_fifo.sv =====
// small register queue used between the pipeline parts
module dss_fifo #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 2,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/dss_front.sv =====
// front part: checks validity, clamps the pulse and queues classified items
module dss_front import dss_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_push,
   input  req_type  req_data,
   output logic     req_full,
   input  cfg_type  cfg,
   input  logic     work_pop,
   output work_type work_data,
   output logic     work_empty
);

   work_type   classified;
   logic [15:0] pulse_lo;

   // validity check and pulse clamp, lower clamp first
   always_comb begin
      pulse_lo = (req_data.pulse_request < cfg.min_pulse_ms) ? cfg.min_pulse_ms
                                                             : req_data.pulse_request;
      classified.cmd        = req_data.cmd;
      classified.ok         = (req_data.event_kind == cfg.strike_kind_code) &&
                              (req_data.strike_id != '0) &&
                              (req_data.delay_ms <= cfg.max_delay_ms);
      classified.now_ms     = req_data.now_ms;
      classified.strike_id  = req_data.strike_id;
      classified.delay_ms   = req_data.delay_ms;
      classified.pulse_ms   = (pulse_lo > cfg.max_pulse_ms) ? cfg.max_pulse_ms : pulse_lo;
   end

   // queue toward the back part
   dss_fifo #(
      .WIDTH ($bits(work_type)),
      .DEPTH (2)
   ) u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (classified),
      .full      (req_full),
      .pop       (work_pop),
      .pop_data  (work_data),
      .empty     (work_empty)
   );

endmodule

// ===== hdl/dss_back.sv =====
// back part: id history search, strike arming and tick handling
module dss_back import dss_pkg::*; #(
   parameter  int SEEN_DEPTH = SEEN_DEPTH_DEF,
   localparam int IDX_W      = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1,
   localparam int FILL_W     = $clog2(SEEN_DEPTH + 1)
) (
   input  logic        clock,
   input  logic        reset,
   input  work_type    work_data,
   input  logic        work_empty,
   output logic        work_pop,
   input  logic [15:0] max_late_ms,
   input  logic        rsp_full,
   output logic        rsp_push,
   output rsp_type     rsp_data
);

   typedef enum logic [1:0] {
      BK_IDLE   = 2'b01,
      BK_SEARCH = 2'b10
   } back_state_type;

   back_state_type    state_ff, state_in;
   work_type          item_ff, item_in;
   logic [FILL_W-1:0] idx_ff, idx_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic              pending_ff, pending_in;
   logic [31:0]       fire_time_ff, fire_time_in;
   logic [15:0]       held_pulse_ff, held_pulse_in;

   logic              rd_en;
   logic [31:0]       rd_data;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [31:0]       late;
   logic              hit;

   // history of seen ids
   dss_ram #(
      .WIDTH (32),
      .DEPTH (SEEN_DEPTH)
   ) u_seen_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (item_ff.strike_id),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign late    = work_data.now_ms - fire_time_ff;
   assign hit     = rd_pend_ff && (rd_data == item_ff.strike_id);
   assign wr_addr = (fill_ff < FILL_W'(SEEN_DEPTH)) ? fill_ff[IDX_W-1:0] : ptr_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      idx_in        = idx_ff;
      rd_pend_in    = 1'b0;
      fill_in       = fill_ff;
      ptr_in        = ptr_ff;
      pending_in    = pending_ff;
      fire_time_in  = fire_time_ff;
      held_pulse_in = held_pulse_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      work_pop      = 1'b0;
      rsp_push      = 1'b0;
      rsp_data      = '{status: ST_INVALID, pulse_ms: '0};

      unique case (state_ff)
         BK_IDLE: begin
            if (!work_empty && !rsp_full) begin
               work_pop = 1'b1;
               if (work_data.cmd == CMD_TICK) begin
                  // tick: wrap-safe lateness check
                  rsp_push = 1'b1;
                  if (!pending_ff) begin
                     rsp_data.status = ST_IDLE;
                  end else if (late[31]) begin
                     rsp_data.status = ST_WAITING;
                  end else begin
                     pending_in = 1'b0;
                     if (late > {16'd0, max_late_ms}) begin
                        rsp_data.status = ST_EXPIRED;
                     end else begin
                        rsp_data.status   = ST_FIRE;
                        rsp_data.pulse_ms = held_pulse_ff;
                     end
                  end
               end else if (!work_data.ok) begin
                  rsp_push        = 1'b1;
                  rsp_data.status = ST_INVALID;
               end else begin
                  item_in  = work_data;
                  idx_in   = '0;
                  state_in = BK_SEARCH;
               end
            end
         end
         BK_SEARCH: begin
            rd_en = (idx_ff < fill_ff);
            if (hit) begin
               rsp_push        = 1'b1;
               rsp_data.status = ST_DUPLICATE;
               state_in        = BK_IDLE;
            end else if (!rd_en && !rd_pend_ff) begin
               // miss: remember the id, then arm unless busy
               rd_en    = 1'b0;
               wr_en    = 1'b1;
               rsp_push = 1'b1;
               state_in = BK_IDLE;
               if (fill_ff < FILL_W'(SEEN_DEPTH)) begin
                  fill_in = fill_ff + 1'b1;
               end else begin
                  ptr_in = (ptr_ff == IDX_W'(SEEN_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
               end
               if (pending_ff) begin
                  rsp_data.status = ST_BUSY;
               end else begin
                  pending_in      = 1'b1;
                  fire_time_in    = item_ff.now_ms + {16'd0, item_ff.delay_ms};
                  held_pulse_in   = item_ff.pulse_ms;
                  rsp_data.status = (item_ff.delay_ms != '0) ? ST_ARMED_FUTURE
                                                             : ST_ARMED_NOW;
               end
            end else begin
               if (rd_en) begin
                  idx_in = idx_ff + 1'b1;
               end
               rd_pend_in = rd_en;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         idx_ff     <= '0;
         rd_pend_ff <= 1'b0;
         fill_ff    <= '0;
         ptr_ff     <= '0;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         rd_pend_ff <= rd_pend_in;
         fill_ff    <= fill_in;
         ptr_ff     <= ptr_in;
         pending_ff <= pending_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      fire_time_ff  <= fire_time_in;
      held_pulse_ff <= held_pulse_in;
   end

endmodule

// ===== hdl/dedup_strike_scheduler.sv =====
// top level of the deduplicating solenoid strike scheduler
//
//   port group | direction | handshake         | payload
//   req_       | in        | push / full       | req_data  (req_type)
//   rsp_       | out       | pop / empty       | rsp_data  (rsp_type)
//   csr_       | in        | write_enable only | csr_index, csr_wdata
//
// a tick or an invalid event is handled in the back part without a history search
// a valid new event searches the history ram one entry per cycle through its single
// registered read port; a duplicate ends in the cycle after its match is read
// a two-entry queue before and after the back part lets each side stall on its own
// reset is synchronous; it empties the queues and the history, no clearing pass
module dedup_strike_scheduler import dss_pkg::*; #(
   parameter int SEEN_DEPTH = SEEN_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  req_type              req_data,
   output logic                 req_full,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_type              rsp_data,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   work_type work_data;
   logic     work_empty;
   logic     work_pop;
   logic     rsp_full_int;
   logic     rsp_push_int;
   rsp_type  rsp_push_data;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_STRIKE_KIND: cfg_in.strike_kind_code = csr_wdata[7:0];
            CSR_MAX_DELAY:   cfg_in.max_delay_ms     = csr_wdata;
            CSR_MIN_PULSE:   cfg_in.min_pulse_ms     = csr_wdata;
            CSR_MAX_PULSE:   cfg_in.max_pulse_ms     = csr_wdata;
            CSR_MAX_LATE:    cfg_in.max_late_ms      = csr_wdata;
            default:         cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{strike_kind_code: STRIKE_KIND_RST,
                     max_delay_ms:     MAX_DELAY_RST,
                     min_pulse_ms:     MIN_PULSE_RST,
                     max_pulse_ms:     MAX_PULSE_RST,
                     max_late_ms:      MAX_LATE_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify and queue
   dss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .cfg        (cfg_ff),
      .work_pop   (work_pop),
      .work_data  (work_data),
      .work_empty (work_empty)
   );

   // search, arm and tick
   dss_back #(
      .SEEN_DEPTH (SEEN_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .work_data   (work_data),
      .work_empty  (work_empty),
      .work_pop    (work_pop),
      .max_late_ms (cfg_ff.max_late_ms),
      .rsp_full    (rsp_full_int),
      .rsp_push    (rsp_push_int),
      .rsp_data    (rsp_push_data)
   );

   // result queue
   dss_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push_int),
      .push_data (rsp_push_data),
      .full      (rsp_full_int),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

   // back part never writes a full result queue
   assert property (@(posedge clock) disable iff (reset) rsp_push_int |-> !rsp_full_int)
      else $error("result beat pushed into full queue");

   // back part never takes from an empty work queue
   assert property (@(posedge clock) disable iff (reset) work_pop |-> !work_empty)
      else $error("work beat popped from empty queue");

   // a result pushed into an empty queue shows on the next cycle
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_push_int && rsp_empty) |=> !rsp_empty)
      else $error("pushed result beat not visible");

endmodule

// ===== bench/strike_check_pkg.sv =====
// scoreboard class that predicts and checks the strike scheduler's result beats
`timescale 1ns / 100ps

package strike_check_pkg;
   import dss_pkg::*;

   class strike_scoreboard;
      // register copy and scheduler state mirrored from the block
      cfg_type     regs;
      logic [31:0] seen_ids [SEEN_DEPTH_DEF];
      int unsigned seen_fill;
      int unsigned replace_ptr;
      bit          pending;
      logic [31:0] fire_at;
      logic [15:0] held_pulse;

      // result beats owed by the block, oldest first
      rsp_type     outcomes [$];
      int unsigned mismatches;
      int unsigned status_hits [9];

      function new();
         regs = '{strike_kind_code: STRIKE_KIND_RST, max_delay_ms: MAX_DELAY_RST,
                  min_pulse_ms: MIN_PULSE_RST, max_pulse_ms: MAX_PULSE_RST,
                  max_late_ms: MAX_LATE_RST};
         seen_fill   = 0;
         replace_ptr = 0;
         pending     = 1'b0;
         fire_at     = '0;
         held_pulse  = '0;
         mismatches  = 0;
         foreach (status_hits[i]) status_hits[i] = 0;
      endfunction

      // one scheduling step: classify the beat, update state, return its result
      function rsp_type schedule_step(req_type r);
         rsp_type     res;
         bit          known;
         logic [15:0] pulse;
         logic [31:0] late;
         res = '0;
         if (r.cmd == CMD_EVENT) begin
            if (r.event_kind != regs.strike_kind_code || r.strike_id == '0 ||
                r.delay_ms > regs.max_delay_ms) begin
               res.status = ST_INVALID;
            end else begin
               // search only the entries written so far
               known = 1'b0;
               for (int i = 0; i < seen_fill; i++)
                  if (seen_ids[i] == r.strike_id) known = 1'b1;
               if (known) begin
                  res.status = ST_DUPLICATE;
               end else begin
                  // fill the history first, then overwrite in ring order
                  if (seen_fill < SEEN_DEPTH_DEF) begin
                     seen_ids[seen_fill] = r.strike_id;
                     seen_fill++;
                  end else begin
                     seen_ids[replace_ptr] = r.strike_id;
                     replace_ptr = (replace_ptr + 1) % SEEN_DEPTH_DEF;
                  end
                  if (pending) begin
                     res.status = ST_BUSY;
                  end else begin
                     // lower clamp first, upper clamp wins when crossed
                     pulse = r.pulse_request;
                     if (pulse < regs.min_pulse_ms) pulse = regs.min_pulse_ms;
                     if (pulse > regs.max_pulse_ms) pulse = regs.max_pulse_ms;
                     pending    = 1'b1;
                     fire_at    = r.now_ms + 32'(r.delay_ms);
                     held_pulse = pulse;
                     res.status = (r.delay_ms != '0) ? ST_ARMED_FUTURE : ST_ARMED_NOW;
                  end
               end
            end
         end else begin
            if (!pending) begin
               res.status = ST_IDLE;
            end else begin
               // wrap-safe lateness, negative means still waiting
               late = r.now_ms - fire_at;
               if (late[31]) begin
                  res.status = ST_WAITING;
               end else begin
                  pending = 1'b0;
                  if (late > 32'(regs.max_late_ms)) begin
                     res.status = ST_EXPIRED;
                  end else begin
                     res.status   = ST_FIRE;
                     res.pulse_ms = held_pulse;
                  end
               end
            end
         end
         return res;
      endfunction

      // accepted input beat: owe its result
      function void note_request(req_type r);
         outcomes.push_back(schedule_step(r));
      endfunction

      // accepted result beat: compare with the oldest owed one
      function void check_outcome(rsp_type got);
         rsp_type want;
         if (outcomes.size() == 0) begin
            $display("%0t: result beat with nothing owed, actual status %0d pulse %0d",
                     $time, got.status, got.pulse_ms);
            mismatches++;
            return;
         end
         want = outcomes.pop_front();
         if (int'(want.status) < 9) status_hits[want.status]++;
         if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            mismatches++;
         end
         if (got.pulse_ms !== want.pulse_ms) begin
            $display("%0t: pulse_ms mismatch, expected %0d, actual %0d",
                     $time, want.pulse_ms, got.pulse_ms);
            mismatches++;
         end
      endfunction
   endclass

endpackage

// ===== bench/tb.sv =====
// top-level bench of the strike scheduler: stimulus, stalls, watchdog and verdict
`timescale 1ns / 100ps

module tb import dss_pkg::*, strike_check_pkg::*; ;

   localparam int STALL_LIMIT  = 3000;
   localparam int PHASE_BEATS  = 80;
   localparam int PHASE_COUNT  = 6;
   localparam int LONG_HOLD    = 300;

   logic                 clock;
   logic                 reset;
   logic                 req_push;
   req_type              req_data;
   logic                 req_full;
   logic                 rsp_empty;
   logic                 rsp_pop;
   rsp_type              rsp_data;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   strike_scoreboard sb;
   int unsigned      sent_count;
   int               tx_gap_pct;
   int               rx_gap_pct;
   logic [31:0]      clock_ms;
   logic [31:0]      recent_ids [$];

   dedup_strike_scheduler u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_data         (req_data),
      .req_full         (req_full),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // event beat builder
   function automatic req_type make_event(logic [7:0] kind, logic [31:0] id,
                                          logic [15:0] delay, logic [15:0] pulse,
                                          logic [31:0] now);
      req_type r;
      r.cmd           = CMD_EVENT;
      r.now_ms        = now;
      r.event_kind    = kind;
      r.strike_id     = id;
      r.delay_ms      = delay;
      r.pulse_request = pulse;
      return r;
   endfunction

   // tick beat builder, unused fields random
   function automatic req_type make_tick(logic [31:0] now);
      req_type r;
      r.cmd           = CMD_TICK;
      r.now_ms        = now;
      r.event_kind    = 8'($urandom);
      r.strike_id     = $urandom;
      r.delay_ms      = 16'($urandom);
      r.pulse_request = 16'($urandom);
      return r;
   endfunction

   // random beat steered by the mirrored state: mostly strike/tick sequences
   function automatic req_type next_random_beat();
      req_type     r;
      int          pick;
      int          shade;
      logic [31:0] id;
      logic [31:0] now;
      logic [15:0] delay;
      logic [15:0] pulse;
      pick     = $urandom_range(0, 99);
      clock_ms = clock_ms + $urandom_range(0, 200);
      // tick against the pending strike: waiting, fire or expired
      if (sb.pending && pick < 55) begin
         shade = $urandom_range(0, 99);
         if (shade < 5)
            now = sb.fire_at - 32'h7FFF_FFFF;
         else if (shade < 30)
            now = sb.fire_at - $urandom_range(1, 5000);
         else if (shade < 75)
            now = sb.fire_at + $urandom_range(0, sb.regs.max_late_ms);
         else if (shade < 95)
            now = sb.fire_at + sb.regs.max_late_ms + 32'd1 + $urandom_range(0, 100000);
         else
            now = sb.fire_at + 32'h7FFF_FFFF;
         clock_ms = now;
         return make_tick(now);
      end
      // idle tick at a random time
      if (!sb.pending && pick < 15) return make_tick($urandom);
      // noise: broken events
      if (pick >= 85) begin
         r = make_event(8'($urandom), $urandom, 16'($urandom), 16'($urandom), clock_ms);
         case ($urandom_range(0, 3))
            0: r.strike_id = '0;
            1: r.event_kind = sb.regs.strike_kind_code ^ 8'($urandom_range(1, 255));
            2: if (sb.regs.max_delay_ms != 16'hFFFF)
                  r.delay_ms = 16'($urandom_range(sb.regs.max_delay_ms + 1, 65535));
            default: ;
         endcase
         return r;
      end
      // well-formed strike with fresh or recently used id
      id = $urandom;
      if (recent_ids.size() != 0 && $urandom_range(0, 99) < 35)
         id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
      if (id == '0) id = 32'd1;
      recent_ids.push_back(id);
      if (recent_ids.size() > 40) void'(recent_ids.pop_front());
      shade = $urandom_range(0, 9);
      if (shade == 0)
         delay = '0;
      else if (shade == 1)
         delay = sb.regs.max_delay_ms;
      else
         delay = 16'($urandom_range(0, sb.regs.max_delay_ms));
      pulse = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
      return make_event(sb.regs.strike_kind_code, id, delay, pulse, clock_ms);
   endfunction

   // offer one input beat and hold it until accepted
   task automatic drive_req(input req_type r);
      req_data <= r;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      sb.note_request(r);
      sent_count++;
   endtask

   // sender gap
   task automatic idle_req(input int cycles);
      req_push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // wait until every owed result beat has come back
   task automatic drain();
      while (sb.outcomes.size() != 0) @(posedge clock);
   endtask

   // write all five registers, one per cycle
   task automatic apply_settings(input cfg_type c);
      logic [CSR_IDX_W-1:0] idx  [5];
      logic [CSR_W-1:0]     vals [5];
      idx  = '{CSR_STRIKE_KIND, CSR_MAX_DELAY, CSR_MIN_PULSE, CSR_MAX_PULSE, CSR_MAX_LATE};
      vals = '{{8'd0, c.strike_kind_code}, c.max_delay_ms, c.min_pulse_ms,
               c.max_pulse_ms, c.max_late_ms};
      for (int i = 0; i < 5; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= idx[i];
         csr_wdata        <= vals[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      sb.regs = c;
   endtask

   // result side: check accepted beats, random stall bursts, one long hold-off
   initial begin : receiver
      int hold;
      bit long_hold_done;
      hold           = 0;
      long_hold_done = 1'b0;
      rsp_pop <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) sb.check_outcome(rsp_data);
         if (hold > 0) begin
            hold--;
            rsp_pop <= 1'b0;
         end else if (!long_hold_done && sent_count >= 150) begin
            // long hold-off so the block fills and stalls its input
            long_hold_done = 1'b1;
            hold           = LONG_HOLD - 1;
            rsp_pop <= 1'b0;
         end else if (rx_gap_pct != 0 && $urandom_range(0, 99) < rx_gap_pct) begin
            hold = $urandom_range(0, 7);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no beat accepted on either side
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // main sequence
   initial begin : stimulus
      req_type opening [$];
      cfg_type c;
      req_type r;
      sb         = new();
      sent_count = 0;
      tx_gap_pct = 20;
      rx_gap_pct = 20;
      clock_ms   = 32'd1000;
      reset            <= 1'b1;
      req_push         <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed opening at reset settings
      opening.push_back(make_tick(32'd0));                                    // idle
      opening.push_back(make_event(8'd0, 32'd5, 16'd10, 16'd10, 32'd0));      // wrong kind
      opening.push_back(make_event(8'd1, 32'd0, 16'd10, 16'd10, 32'd0));      // id zero
      opening.push_back(make_event(8'd1, 32'd7, 16'd10001, 16'd10, 32'd0));   // delay too long
      opening.push_back(make_event(8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
      opening.push_back(make_event(8'd1, 32'd1, 16'd0, 16'd0, 32'd1000));     // armed now, low clamp
      opening.push_back(make_event(8'd1, 32'd1, 16'd0, 16'd0, 32'd1000));     // duplicate
      opening.push_back(make_event(8'd1, 32'd2, 16'd10000, 16'd9, 32'd1000)); // busy, remembered
      opening.push_back(make_event(8'd1, 32'd2, 16'd5, 16'd9, 32'd1000));     // duplicate of busy id
      opening.push_back(make_tick(32'd1000));                                 // fire
      opening.push_back(make_tick(32'd1000));                                 // idle again
      // fire time wraps past zero, high clamp
      opening.push_back(make_event(8'd1, 32'hFFFF_FFFF, 16'd10000, 16'hFFFF, 32'hFFFF_F000));
      opening.push_back(make_tick(32'hFFFF_FFFF));                            // waiting across wrap
      opening.push_back(make_tick(32'h0000_1710 + 32'd50));                   // fire at max lateness
      opening.push_back(make_event(8'd1, 32'd3, 16'd5, 16'd50, 32'd0));
      opening.push_back(make_tick(32'd56));                                   // one past: expired
      opening.push_back(make_event(8'd1, 32'd4, 16'd0, 16'd20, 32'd0));
      opening.push_back(make_tick(32'h8000_0000));                            // sign bit: waiting
      opening.push_back(make_tick(32'h7FFF_FFFF));                            // far late: expired
      opening.push_back(make_event(8'd1, 32'd6, 16'd1, 16'd37, 32'd100));
      opening.push_back(make_tick(32'd100));                                  // one early: waiting
      opening.push_back(make_tick(32'd101));                                  // fire
      foreach (opening[i]) begin
         if ($urandom_range(0, 99) < tx_gap_pct) idle_req($urandom_range(1, 8));
         drive_req(opening[i]);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         // new settings only once the block has gone quiet
         if (p > 0) begin
            req_push <= 1'b0;
            drain();
            case (p)
               1: c = '{strike_kind_code: 8'($urandom), max_delay_ms: 16'($urandom),
                        min_pulse_ms: 16'($urandom_range(0, 200)),
                        max_pulse_ms: 16'($urandom_range(100, 65535)),
                        max_late_ms: 16'($urandom_range(0, 2000))};
               2: c = '{strike_kind_code: 8'd0, max_delay_ms: 16'd0, min_pulse_ms: 16'd0,
                        max_pulse_ms: 16'd0, max_late_ms: 16'd0};
               3: c = '{strike_kind_code: 8'hFF, max_delay_ms: 16'hFFFF,
                        min_pulse_ms: 16'hFFFF, max_pulse_ms: 16'hFFFF,
                        max_late_ms: 16'hFFFF};
               4: c = '{strike_kind_code: 8'($urandom), max_delay_ms: 16'd3000,
                        min_pulse_ms: 16'd500, max_pulse_ms: 16'd20, max_late_ms: 16'd100};
               default: c = '{strike_kind_code: 8'($urandom), max_delay_ms: 16'($urandom),
                              min_pulse_ms: 16'($urandom), max_pulse_ms: 16'($urandom),
                              max_late_ms: 16'($urandom)};
            endcase
            apply_settings(c);
            clock_ms = (p % 2 == 1) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
         end
         for (int n = 0; n < PHASE_BEATS; n++) begin
            // stall profile per stretch, none in the closing stretch
            if (n % 20 == 0) begin
               if (p == PHASE_COUNT - 1 && n >= 40) begin
                  tx_gap_pct = 0;
                  rx_gap_pct = 0;
               end else begin
                  tx_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
                  rx_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
               end
            end
            r = next_random_beat();
            if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
               idle_req($urandom_range(1, 8));
            drive_req(r);
         end
      end

      // closing: drain, then watch for stray beats
      req_push <= 1'b0;
      drain();
      repeat (40) @(posedge clock);

      $display("covered %0d input beats over %0d register settings, incl. history wrap",
               sent_count, PHASE_COUNT);
      $display("results: fire %0d expired %0d waiting %0d idle %0d busy %0d dup %0d inv %0d",
               sb.status_hits[ST_FIRE], sb.status_hits[ST_EXPIRED],
               sb.status_hits[ST_WAITING], sb.status_hits[ST_IDLE],
               sb.status_hits[ST_BUSY], sb.status_hits[ST_DUPLICATE],
               sb.status_hits[ST_INVALID]);
      if (sb.mismatches == 0 && sb.outcomes.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d result beats never arrived",
                  sb.mismatches, sb.outcomes.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
